[src/hjd_pkg.sv]
// ----------------------------------------------------------------------------
// hjd_pkg
// Shared types and constants of the JPEG Huffman symbol decoder.
// ----------------------------------------------------------------------------
package hjd_pkg;

   localparam int DEFAULT_MAX_CODE_BITS = 16;
   localparam int DEFAULT_SYMBOL_DEPTH  = 256;

   localparam int COUNT_DEPTH  = 16;
   localparam int COUNT_IDX_W  = 4;
   localparam int LEN_W        = 5;
   localparam int BASE_CODE_W  = 17;
   localparam int BASE_INDEX_W = 9;
   localparam int INDEX_SUM_W  = 10;

   localparam logic [BASE_CODE_W-1:0]  BASE_CODE_MAX  = 17'h1FFFF;
   localparam logic [BASE_INDEX_W-1:0] BASE_INDEX_MAX = 9'd511;

   localparam logic [7:0] MARKER_BYTE = 8'hFF;
   localparam logic [7:0] STUFF_BYTE  = 8'h00;

   typedef enum logic [1:0] {
      KIND_COUNT   = 2'd0,
      KIND_SYMBOL  = 2'd1,
      KIND_DATA    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
      logic             bad;
      logic             byte_end;
   } issue_type;

endpackage

[src/hjd_symbol_ram.sv]
// ----------------------------------------------------------------------------
// hjd_symbol_ram
// Symbol store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hjd_symbol_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/hjd_code_walker.sv]
// ----------------------------------------------------------------------------
// hjd_code_walker
// Takes input items, keeps the length counts and walks the code one bit a cycle unless step_ok stalls it.
// ----------------------------------------------------------------------------
module hjd_code_walker
   import hjd_pkg::*;
#(
   parameter int MAX_CODE_BITS = DEFAULT_MAX_CODE_BITS,
   parameter int SYMBOL_DEPTH  = DEFAULT_SYMBOL_DEPTH,
   parameter int ADDR_W        = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              step_ok,
   output issue_type         issue,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr
);

   localparam int CODE_W  = MAX_CODE_BITS;
   localparam int TAKEN_W = $clog2(MAX_CODE_BITS);

   logic                    busy_ff, busy_in;
   logic [7:0]              shift_ff, shift_in;
   logic [2:0]              bit_cnt_ff, bit_cnt_in;
   logic [CODE_W-1:0]       partial_ff, partial_in;
   logic [TAKEN_W-1:0]      taken_ff, taken_in;
   logic [BASE_CODE_W-1:0]  base_code_ff, base_code_in;
   logic [BASE_INDEX_W-1:0] base_index_ff, base_index_in;
   logic                    marker_ff, marker_in;
   logic [7:0]              counts_ff [COUNT_DEPTH];

   kind_type                kind;
   logic [7:0]              position;
   logic [7:0]              byte_value;
   logic                    accept;
   logic                    step;
   logic [CODE_W-1:0]       code;
   logic [BASE_CODE_W-1:0]  code_ext;
   logic [BASE_CODE_W-1:0]  diff;
   logic [7:0]              cnt;
   logic [LEN_W-1:0]        len;
   logic                    hit;
   logic                    at_max;
   logic [INDEX_SUM_W-1:0]  idx;
   logic                    in_range;
   logic [BASE_CODE_W:0]    nb_sum;
   logic [INDEX_SUM_W-1:0]  ni_sum;

   assign kind       = kind_type'(req_tuser);
   assign position   = req_tdata[7:0];
   assign byte_value = req_tdata[15:8];
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign step       = busy_ff && step_ok;

   assign code     = {partial_ff[CODE_W-2:0], shift_ff[7]};
   assign code_ext = BASE_CODE_W'(code);
   assign cnt      = counts_ff[COUNT_IDX_W'(taken_ff)];
   assign len      = LEN_W'(taken_ff) + LEN_W'(1);
   assign diff     = code_ext - base_code_ff;
   assign hit      = (code_ext >= base_code_ff) && (diff < BASE_CODE_W'(cnt));
   assign at_max   = (len == LEN_W'(MAX_CODE_BITS));
   assign idx      = INDEX_SUM_W'(base_index_ff) + INDEX_SUM_W'(diff[7:0]);
   assign in_range = (idx < INDEX_SUM_W'(SYMBOL_DEPTH));
   assign nb_sum   = (BASE_CODE_W+1)'(base_code_ff) + (BASE_CODE_W+1)'(cnt);
   assign ni_sum   = INDEX_SUM_W'(base_index_ff) + INDEX_SUM_W'(cnt);

   assign issue.valid    = step && (hit || at_max);
   assign issue.len      = hit ? len : LEN_W'(MAX_CODE_BITS);
   assign issue.bad      = hit ? !in_range : 1'b1;
   assign issue.byte_end = step && (bit_cnt_ff == 3'd0);

   assign rd_en   = step && hit && in_range;
   assign rd_addr = idx[ADDR_W-1:0];

   assign wr_en   = accept && (kind == KIND_SYMBOL)
                    && ({1'b0, position} < 9'(SYMBOL_DEPTH));
   assign wr_addr = position[ADDR_W-1:0];
   assign wr_data = byte_value;

   always_comb begin
      busy_in       = busy_ff;
      shift_in      = shift_ff;
      bit_cnt_in    = bit_cnt_ff;
      partial_in    = partial_ff;
      taken_in      = taken_ff;
      base_code_in  = base_code_ff;
      base_index_in = base_index_ff;
      marker_in     = marker_ff;
      if (accept) begin
         unique case (kind)
            KIND_COUNT, KIND_SYMBOL: begin
            end
            KIND_RESTART: begin
               partial_in    = '0;
               taken_in      = '0;
               base_code_in  = '0;
               base_index_in = '0;
               marker_in     = 1'b0;
            end
            KIND_DATA: begin
               bit_cnt_in = 3'd7;
               if (marker_ff) begin
                  marker_in = 1'b0;
                  busy_in   = 1'b1;
                  shift_in  = (byte_value == STUFF_BYTE) ? MARKER_BYTE : byte_value;
               end else if (byte_value == MARKER_BYTE) begin
                  marker_in = 1'b1;
               end else begin
                  busy_in  = 1'b1;
                  shift_in = byte_value;
               end
            end
         endcase
      end else if (step) begin
         shift_in   = {shift_ff[6:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 3'd1;
         if (bit_cnt_ff == 3'd0) begin
            busy_in = 1'b0;
         end
         if (hit || at_max) begin
            partial_in    = '0;
            taken_in      = '0;
            base_code_in  = '0;
            base_index_in = '0;
         end else begin
            partial_in    = code;
            taken_in      = len[TAKEN_W-1:0];
            base_code_in  = (nb_sum[BASE_CODE_W-1] != 1'b0 || nb_sum[BASE_CODE_W] != 1'b0)
                            ? BASE_CODE_MAX : {nb_sum[BASE_CODE_W-2:0], 1'b0};
            base_index_in = (ni_sum > INDEX_SUM_W'(BASE_INDEX_MAX))
                            ? BASE_INDEX_MAX : ni_sum[BASE_INDEX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         bit_cnt_ff    <= '0;
         partial_ff    <= '0;
         taken_ff      <= '0;
         base_code_ff  <= '0;
         base_index_ff <= '0;
         marker_ff     <= 1'b0;
         for (int i = 0; i < COUNT_DEPTH; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         busy_ff       <= busy_in;
         bit_cnt_ff    <= bit_cnt_in;
         partial_ff    <= partial_in;
         taken_ff      <= taken_in;
         base_code_ff  <= base_code_in;
         base_index_ff <= base_index_in;
         marker_ff     <= marker_in;
         if (accept && (kind == KIND_COUNT) && (position[7:4] == 4'd0)) begin
            counts_ff[position[COUNT_IDX_W-1:0]] <= byte_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

[src/hjd_result_stage.sv]
// ----------------------------------------------------------------------------
// hjd_result_stage
// Holds a found code until it is known whether it ends its byte, then
// hands it to the output register.
// ----------------------------------------------------------------------------
module hjd_result_stage
   import hjd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  issue_type   issue,
   input  logic [7:0]  rd_data,
   output logic        step_ok,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic             pend_v_ff, pend_v_in;
   logic             pend_last_ff, pend_last_in;
   logic [LEN_W-1:0] pend_len_ff, pend_len_in;
   logic             pend_bad_ff, pend_bad_in;
   logic             out_v_ff, out_v_in;
   logic [7:0]       out_sym_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic             out_bad_ff;
   logic             out_last_ff;
   logic             out_free;
   logic             release_pend;

   assign out_free     = !out_v_ff || rsp_tready;
   assign step_ok      = !pend_v_ff || out_free;
   assign release_pend = pend_v_ff && out_free && (pend_last_ff || issue.valid);

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_last_in = pend_last_ff;
      pend_len_in  = pend_len_ff;
      pend_bad_in  = pend_bad_ff;
      if (issue.valid) begin
         pend_v_in    = 1'b1;
         pend_last_in = issue.byte_end;
         pend_len_in  = issue.len;
         pend_bad_in  = issue.bad;
      end else begin
         if (release_pend) begin
            pend_v_in = 1'b0;
         end
         if (issue.byte_end) begin
            pend_last_in = 1'b1;
         end
      end
      if (release_pend) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         pend_last_ff <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         pend_v_ff    <= pend_v_in;
         pend_last_ff <= pend_last_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_len_ff <= pend_len_in;
      pend_bad_ff <= pend_bad_in;
      if (release_pend) begin
         out_sym_ff  <= pend_bad_ff ? 8'd0 : rd_data;
         out_len_ff  <= pend_len_ff;
         out_bad_ff  <= pend_bad_ff;
         out_last_ff <= pend_last_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'b000, out_len_ff, out_sym_ff};
   assign rsp_tuser  = out_bad_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[src/jpeg_huffman_symbol_decoder.sv]
// ----------------------------------------------------------------------------
// jpeg_huffman_symbol_decoder
// Canonical JPEG Huffman symbol decoder with loadable count and symbol tables.
// ----------------------------------------------------------------------------
// Load items (count or symbol writes) and restart items leave the decoder
// free. A data byte is taken and then walked one code bit per cycle; the walk
// pauses while a found code cannot move on because the output register is
// still occupied, and no new item is taken until the byte's last bit is
// walked. A 0xFF marker byte is only noted. Each bit step compares the running
// code against the count of the current length and, on a match, reads the
// symbol memory, whose read latency is hidden while the found code is pending.
// The symbol memory has no reset and must be loaded before codes that use it.
// ----------------------------------------------------------------------------
module jpeg_huffman_symbol_decoder
   import hjd_pkg::*;
#(
   parameter int MAX_CODE_BITS = DEFAULT_MAX_CODE_BITS,
   parameter int SYMBOL_DEPTH  = DEFAULT_SYMBOL_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // position [7:0], byte_value [15:8]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // symbol [7:0], code_length [12:8], zero [15:13]
   output logic        rsp_tuser,   // bad_code [0]
   output logic        rsp_tlast
);

   localparam int ADDR_W = $clog2(SYMBOL_DEPTH);

   issue_type         issue;
   logic              step_ok;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   hjd_code_walker #(
      .MAX_CODE_BITS(MAX_CODE_BITS),
      .SYMBOL_DEPTH (SYMBOL_DEPTH),
      .ADDR_W       (ADDR_W)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .step_ok   (step_ok),
      .issue     (issue),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   hjd_symbol_ram #(
      .DEPTH (SYMBOL_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   hjd_result_stage u_result (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rd_data   (rd_data),
      .step_ok   (step_ok),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
